// ===== hdl/gif_uncompressed_code_unpacker_core_defines.svh =====
// Assertion macros shared by the code unpacker.
// Each one samples on the rising clock edge and is switched off during reset.
`ifndef GIF_UNCOMPRESSED_CODE_UNPACKER_CORE_DEFINES_SVH
`define GIF_UNCOMPRESSED_CODE_UNPACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GUCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GUCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gucu_pkg.sv =====
`timescale 1ns / 1ps

package gucu_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_LIMIT = 1'd1;

  // Register reset values and the legal code size range.
  localparam logic [3:0]  MCS_RESET   = 4'd8;
  localparam logic [23:0] LIMIT_RESET = 24'hFFFFFF;
  localparam logic [3:0]  MCS_MIN     = 4'd2;
  localparam logic [3:0]  MCS_MAX     = 4'd8;

  // Result kinds.
  localparam logic [2:0] K_PIXEL     = 3'd0;
  localparam logic [2:0] K_ENDCODE   = 3'd1;
  localparam logic [2:0] K_DONE      = 3'd2;
  localparam logic [2:0] K_PREMATURE = 3'd3;
  localparam logic [2:0] K_OVERFLOW  = 3'd4;
  localparam logic [2:0] K_TRAILING  = 3'd5;

  // What the code extraction unit reports about the head of the bit buffer.
  typedef struct packed {
    logic        has_code;
    logic        is_end;
    logic        is_clear;
    logic [7:0]  pixel;
    logic [15:0] bits_next;
    logic [4:0]  count_next;
  } code_info_t;

  // One result on its way to the output register.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pixel;
    logic       last;
  } result_t;

endpackage

// ===== hdl/gucu_code_unit.sv =====
`timescale 1ns / 1ps

module gucu_code_unit import gucu_pkg::*; (
  input  logic [3:0]  root_size,
  input  logic [15:0] bit_buffer,
  input  logic [4:0]  bit_count,
  output code_info_t  info
);

  logic [3:0]  mcs_eff;
  logic [3:0]  width;
  logic [15:0] code_mask;
  logic [15:0] code;
  logic [15:0] clr_code;
  logic [15:0] end_code;

  // Clamp the code size, then cut the lowest code off the buffer.
  always_comb begin
    if (root_size < MCS_MIN) begin
      mcs_eff = MCS_MIN;
    end else if (root_size > MCS_MAX) begin
      mcs_eff = MCS_MAX;
    end else begin
      mcs_eff = root_size;
    end
    width     = mcs_eff + 4'd1;
    code_mask = (16'd1 << width) - 16'd1;
    code      = bit_buffer & code_mask;
    clr_code  = 16'd1 << mcs_eff;
    end_code  = clr_code + 16'd1;

    info.has_code   = bit_count >= {1'b0, width};
    info.is_end     = code == end_code;
    info.is_clear   = code == clr_code;
    info.pixel      = code[7:0];
    info.bits_next  = bit_buffer >> width;
    info.count_next = bit_count - {1'b0, width};
  end

endmodule

// ===== hdl/gucu_out_buf.sv =====
`timescale 1ns / 1ps

module gucu_out_buf import gucu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    res,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] pixel,
  output logic       last
);

  // Space is there when the register is empty or is being emptied now.
  assign free = !out_valid || out_ready;

  // Output register: holds one result until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      kind  <= res.kind;
      pixel <= res.pixel;
      last  <= res.last;
    end
  end

endmodule

// ===== hdl/gif_uncompressed_code_unpacker_core.sv =====
`timescale 1ns / 1ps
// Channel  | Signals                                | Direction
// ---------+----------------------------------------+----------
// config   | cfg_wr_en, cfg_index, cfg_data         | in
// input    | in_valid/in_ready, data_byte, first    | in
// output   | out_valid/out_ready, kind, pixel, last | out
//
// A payload byte is taken in S_IDLE; S_LOOP then cuts its codes one at a
// time through the shared extraction unit until it finds the buffer
// exhausted, and S_FLUSH flushes the held result.
// Length bytes and bytes after the end code go from S_IDLE to S_FLUSH.
// Reset is synchronous and needs no clearing pass; a stalled output holds the
// sequencer whenever a held result must move into a full output register.

`include "gif_uncompressed_code_unpacker_core_defines.svh"

module gif_uncompressed_code_unpacker_core import gucu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            kind,
  output logic [7:0]            pixel,
  output logic                  last
);

  typedef enum logic [1:0] {S_IDLE, S_LOOP, S_FLUSH} state_t;
  typedef enum logic [1:0] {PH_LEN, PH_DATA, PH_AFTER, PH_HALT} phase_t;

  logic [3:0]  root_size;
  logic [23:0] pixel_limit;

  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] bit_buffer, bit_buffer_next;
  logic [4:0]  bit_count, bit_count_next;
  logic [23:0] pixels_out, pixels_out_next;
  logic        pend_valid, pend_valid_next;
  logic [2:0]  pend_kind, pend_kind_next;
  logic [7:0]  pend_pixel, pend_pixel_next;

  phase_t      cur_phase;
  logic [7:0]  cur_bytes_left;
  logic [15:0] cur_bit_buffer;
  logic [4:0]  cur_bit_count;
  logic [23:0] cur_pixels_out;

  code_info_t  info;
  result_t     out_res;
  logic        out_push;
  logic        out_free;

  assign in_ready = state == S_IDLE;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_size   <= MCS_RESET;
      pixel_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROOT_SIZE:   root_size   <= cfg_data[3:0];
        CFG_PIXEL_LIMIT: pixel_limit <= cfg_data[23:0];
        default:         ;
      endcase
    end
  end

  // Shared code extraction unit, used once per loop cycle.
  gucu_code_unit u_code (
    .root_size  (root_size),
    .bit_buffer (bit_buffer),
    .bit_count  (bit_count),
    .info       (info)
  );

  gucu_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .res       (out_res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .pixel     (pixel),
    .last      (last)
  );

  // State as seen by an incoming byte, after an optional restart.
  always_comb begin
    if (first) begin
      cur_phase      = PH_LEN;
      cur_bytes_left = 8'd0;
      cur_bit_buffer = 16'd0;
      cur_bit_count  = 5'd0;
      cur_pixels_out = 24'd0;
    end else begin
      cur_phase      = phase;
      cur_bytes_left = bytes_left;
      cur_bit_buffer = bit_buffer;
      cur_bit_count  = bit_count;
      cur_pixels_out = pixels_out;
    end
  end

  // Sequencer: take a byte, cut codes one per cycle unless the output stalls,
  // then flush the held result with its last flag. One result is always held
  // back so that the last flag can be set once it is known nothing follows it.
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bytes_left_next = bytes_left;
    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    pixels_out_next = pixels_out;
    pend_valid_next = pend_valid;
    pend_kind_next  = pend_kind;
    pend_pixel_next = pend_pixel;
    out_push        = 1'b0;
    out_res.kind    = pend_kind;
    out_res.pixel   = pend_pixel;
    out_res.last    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          phase_next      = cur_phase;
          bytes_left_next = cur_bytes_left;
          bit_buffer_next = cur_bit_buffer;
          bit_count_next  = cur_bit_count;
          pixels_out_next = cur_pixels_out;
          state_next      = S_FLUSH;
          unique case (cur_phase)
            PH_LEN: begin
              if (data_byte == 8'd0) begin
                pend_valid_next = 1'b1;
                pend_kind_next  = K_PREMATURE;
                pend_pixel_next = 8'd0;
                phase_next      = PH_HALT;
              end else begin
                bytes_left_next = data_byte;
                phase_next      = PH_DATA;
              end
            end
            PH_DATA: begin
              bit_buffer_next = cur_bit_buffer | (16'(data_byte) << cur_bit_count);
              bit_count_next  = cur_bit_count + 5'd8;
              bytes_left_next = cur_bytes_left - 8'd1;
              state_next      = S_LOOP;
            end
            PH_AFTER: begin
              pend_valid_next = 1'b1;
              pend_pixel_next = 8'd0;
              if (cur_bytes_left != 8'd0 || data_byte != 8'd0) begin
                pend_kind_next = K_TRAILING;
              end else begin
                pend_kind_next = K_DONE;
              end
              phase_next = PH_HALT;
            end
            default: ;
          endcase
        end
      end

      S_LOOP: begin
        if (phase != PH_DATA || !info.has_code) begin
          // Nothing more to cut from this byte.
          if (phase == PH_DATA && bytes_left == 8'd0) begin
            phase_next = PH_LEN;
          end
          state_next = S_FLUSH;
        end else if (!(!info.is_clear && pend_valid && !out_free)) begin
          bit_buffer_next = info.bits_next;
          bit_count_next  = info.count_next;
          if (!info.is_clear) begin
            // A new result sends the held one on, not yet the last.
            out_push        = pend_valid;
            pend_valid_next = 1'b1;
            pend_pixel_next = 8'd0;
            if (info.is_end) begin
              pend_kind_next  = K_ENDCODE;
              bit_buffer_next = 16'd0;
              bit_count_next  = 5'd0;
              phase_next      = PH_AFTER;
            end else if (pixels_out >= pixel_limit) begin
              pend_kind_next = K_OVERFLOW;
              phase_next     = PH_HALT;
            end else begin
              pend_kind_next  = K_PIXEL;
              pend_pixel_next = info.pixel;
              pixels_out_next = pixels_out + 24'd1;
            end
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_push        = 1'b1;
          out_res.last    = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // State and held result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_LEN;
      bytes_left <= 8'd0;
      bit_buffer <= 16'd0;
      bit_count  <= 5'd0;
      pixels_out <= 24'd0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
      pixels_out <= pixels_out_next;
      pend_valid <= pend_valid_next;
    end
    pend_kind  <= pend_kind_next;
    pend_pixel <= pend_pixel_next;
  end

  `GUCU_ASSERT_NOW(a_idle_nothing_held, state == S_IDLE, !pend_valid, "result held while idle")
  `GUCU_ASSERT_NOW(a_push_has_room, out_push, out_free, "output register overwritten")
  `GUCU_ASSERT_NOW(a_count_bound, 1'b1, bit_count <= 5'd16, "bit count beyond buffer")
  `GUCU_ASSERT_NEXT(a_loop_exits, state == S_LOOP && phase != PH_DATA, state == S_FLUSH, "loop kept running")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gucu_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 310;

  typedef enum logic [1:0] {EXPECT_LEN, IN_BLOCK, AFTER_END, HALTED} stream_phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROOT_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = 8'd0;
  logic                  first = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            kind;
  logic [7:0]            pixel;
  logic                  last;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int unsigned code_list[$];
  logic [7:0]  payload[$];

  gif_uncompressed_code_unpacker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .pixel     (pixel),
    .last      (last)
  );

  always #5 clk = ~clk;

  // Code width for a minimum code size, with out-of-range sizes clamped.
  function automatic int unsigned code_width(logic [3:0] mcs);
    if (mcs < MCS_MIN) return int'(MCS_MIN) + 1;
    if (mcs > MCS_MAX) return int'(MCS_MAX) + 1;
    return int'(mcs) + 1;
  endfunction

  function automatic result_t make_result(logic [2:0] k, logic [7:0] p);
    result_t r;
    r.kind  = k;
    r.pixel = p;
    r.last  = 1'b0;
    return r;
  endfunction

  class unpack_scoreboard;
    logic [3:0]    root_size;
    logic [23:0]   limit;
    stream_phase_t phase;
    logic [7:0]    bytes_left;
    logic [15:0]   bit_buf;
    logic [4:0]    bit_cnt;
    logic [23:0]   pixels_out;
    result_t       pending_results[$];
    int            errors;
    int            seen_bytes;

    function new();
      root_size  = MCS_RESET;
      limit      = LIMIT_RESET;
      errors     = 0;
      seen_bytes = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      phase      = EXPECT_LEN;
      bytes_left = 8'd0;
      bit_buf    = 16'd0;
      bit_cnt    = 5'd0;
      pixels_out = 24'd0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_ROOT_SIZE) root_size = value[3:0];
      else limit = value[23:0];
    endfunction

    // Work out the results that one accepted byte request causes.
    function void note_byte(logic [7:0] b, logic f);
      result_t     produced[$];
      int unsigned width;
      int unsigned clr_code;
      int unsigned end_code;
      int unsigned code;
      int unsigned buf_w;
      int unsigned cnt_w;
      if (f) clear_stream();
      seen_bytes++;
      width    = code_width(root_size);
      clr_code = 1 << (width - 1);
      end_code = clr_code + 1;
      case (phase)
        EXPECT_LEN: begin
          if (b == 8'd0) begin
            produced.push_back(make_result(K_PREMATURE, 8'd0));
            phase = HALTED;
          end else begin
            bytes_left = b;
            phase = IN_BLOCK;
          end
        end
        IN_BLOCK: begin
          buf_w = (32'(bit_buf) | (32'(b) << bit_cnt)) & 32'hFFFF;
          cnt_w = 32'(bit_cnt) + 8;
          bytes_left = bytes_left - 8'd1;
          // Cut whole codes from the bottom of the buffer.
          while (cnt_w >= width && phase == IN_BLOCK) begin
            code  = buf_w & ((1 << width) - 1);
            buf_w = buf_w >> width;
            cnt_w = cnt_w - width;
            if (code == end_code) begin
              produced.push_back(make_result(K_ENDCODE, 8'd0));
              buf_w = 0;
              cnt_w = 0;
              phase = AFTER_END;
            end else if (code != clr_code) begin
              if (pixels_out >= limit) begin
                produced.push_back(make_result(K_OVERFLOW, 8'd0));
                phase = HALTED;
              end else begin
                produced.push_back(make_result(K_PIXEL, code[7:0]));
                pixels_out = pixels_out + 24'd1;
              end
            end
          end
          bit_buf = buf_w[15:0];
          bit_cnt = cnt_w[4:0];
          if (phase == IN_BLOCK && bytes_left == 8'd0) phase = EXPECT_LEN;
        end
        AFTER_END: begin
          if (bytes_left != 8'd0 || b != 8'd0)
            produced.push_back(make_result(K_TRAILING, 8'd0));
          else
            produced.push_back(make_result(K_DONE, 8'd0));
          phase = HALTED;
        end
        default: ;
      endcase
      if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
      foreach (produced[i]) pending_results.push_back(produced[i]);
    endfunction

    // Compare a result request with the oldest expectation.
    function void check_result(logic [2:0] k, logic [7:0] p, logic l);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d pixel %0d last %0d", $time, k, p, l);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (k !== want.kind || p !== want.pixel || l !== want.last) begin
          $display("%0t: mismatch: expected kind %0d pixel %0d last %0d, got kind %0d pixel %0d last %0d",
                   $time, want.kind, want.pixel, want.last, k, p, l);
          errors++;
        end
      end
    endfunction
  endclass

  unpack_scoreboard sb;

  // Output side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor both channels and keep the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(data_byte, first);
      if (out_valid && out_ready) sb.check_result(kind, pixel, last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL gif_uncompressed_code_unpacker_core");
        $finish;
      end
    end
  end

  // Offer one byte request; called and returning at a falling edge.
  task automatic send_byte(logic [7:0] b, logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    first     <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until the block has gone quiet, then write one register.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_wr_en <= 1'b1;
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Pack the code list LSB first into payload bytes, with random padding bits.
  function automatic void pack_codes(int unsigned width);
    int unsigned acc;
    int unsigned cnt;
    payload.delete();
    acc = 0;
    cnt = 0;
    foreach (code_list[i]) begin
      acc = acc | (code_list[i] << cnt);
      cnt = cnt + width;
      while (cnt >= 8) begin
        payload.push_back(acc[7:0]);
        acc = acc >> 8;
        cnt = cnt - 8;
      end
    end
    if (cnt > 0) payload.push_back(8'((acc | ($urandom << cnt)) & 32'hFF));
  endfunction

  // Frame the payload into sub-blocks and send it, then an optional terminator.
  task automatic send_image(int unsigned max_sub, int terminator);
    int unsigned pos;
    int unsigned len;
    int unsigned room;
    logic        f;
    pos = 0;
    f = 1'b1;
    while (pos < payload.size()) begin
      room = payload.size() - pos;
      len = $urandom_range((max_sub < room) ? max_sub : room, 1);
      send_byte(8'(len), f);
      f = 1'b0;
      for (int unsigned i = 0; i < len; i++) send_byte(payload[pos + i], 1'b0);
      pos = pos + len;
    end
    if (terminator >= 0) send_byte(8'(terminator), f);
  endtask

  task automatic random_config();
    logic [3:0]  mcs_val;
    logic [23:0] lim;
    mcs_val = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 2));
    case ($urandom_range(3))
      0: lim = 24'($urandom_range(8));
      1: lim = LIMIT_RESET;
      default: lim = 24'($urandom);
    endcase
    write_register(CFG_ROOT_SIZE, 24'(mcs_val));
    write_register(CFG_PIXEL_LIMIT, lim);
  endtask

  // One random image: mostly well formed, some broken, a little noise.
  task automatic random_image();
    int unsigned width;
    int unsigned clr_code;
    int unsigned end_code;
    int unsigned npix;
    int unsigned v;
    int unsigned c;
    int unsigned max_sub;
    width    = code_width(sb.root_size);
    clr_code = 1 << (width - 1);
    end_code = clr_code + 1;
    v = $urandom_range(99);
    if (v >= 94) begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom), ($urandom_range(3) == 0));
    end else begin
      code_list.delete();
      if ($urandom_range(1)) code_list.push_back(clr_code);
      npix = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      repeat (npix) begin
        c = $urandom_range((1 << width) - 1);
        if (c == end_code || $urandom_range(15) == 0) c = clr_code;
        code_list.push_back(c);
      end
      // Leaving out the end code gives a premature end.
      if (v < 70 || v >= 80) code_list.push_back(end_code);
      pack_codes(width);
      if (v >= 80 && v < 88)
        repeat ($urandom_range(3, 1)) payload.push_back(8'($urandom));
      max_sub = ($urandom_range(9) == 0) ? 255 : $urandom_range(6, 1);
      send_image(max_sub, (v >= 88) ? int'($urandom_range(255, 1)) : 0);
    end
  endtask

  initial begin
    int target;
    int base;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: clear code, pixel, code above the end code, end code, done.
    code_list = '{256, 0, 511, 257};
    pack_codes(9);
    send_image(5, 0);
    // Zero length at the very start.
    send_byte(8'd0, 1'b1);

    // Smallest code size, limit of two: overflow inside a byte, rest ignored.
    write_register(CFG_ROOT_SIZE, 24'd2);
    write_register(CFG_PIXEL_LIMIT, 24'd2);
    code_list = '{4, 7, 3, 6, 1};
    pack_codes(3);
    send_image(6, 0);

    // Code size below range, payload after the end code in the same sub-block or the next.
    write_register(CFG_ROOT_SIZE, 24'd0);
    write_register(CFG_PIXEL_LIMIT, LIMIT_RESET);
    code_list = '{1, 5};
    pack_codes(3);
    payload.push_back(8'hAA);
    send_image(6, -1);

    // Code size above range, longest sub-block cut short by the end code.
    write_register(CFG_ROOT_SIZE, 24'd15);
    code_list = '{257};
    pack_codes(9);
    send_byte(8'hFF, 1'b1);
    send_byte(payload[0], 1'b0);
    send_byte(payload[1], 1'b0);
    send_byte(8'h07, 1'b0);

    // Zero length in mid-stream, then a limit of zero.
    write_register(CFG_ROOT_SIZE, 24'd9);
    write_register(CFG_PIXEL_LIMIT, 24'd0);
    send_byte(8'd1, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'd0, 1'b0);
    code_list = '{52};
    pack_codes(9);
    send_image(1, 0);

    // Random part in four idling phases.
    base = sb.seen_bytes;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      random_config();
      if (ph == 0) begin
        write_register(CFG_PIXEL_LIMIT, LIMIT_RESET);
        hold_request = 1'b1;
      end
      target = base + (RANDOM_BYTES * (ph + 1)) / 4;
      while (sb.seen_bytes < target) begin
        random_image();
        if ($urandom_range(3) == 0 && !(ph == 0 && hold_left > 0)) random_config();
      end
    end

    // Drain and report.
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS gif_uncompressed_code_unpacker_core");
    end else begin
      $display("FAIL gif_uncompressed_code_unpacker_core");
    end
    $finish;
  end

endmodule
